/* rtl/ubac_pkg.sv */
// Package for the unaligned bitmap AND-copy block: widths, register codes,
// result entry type and the low-ones mask helper. No dependencies.
`default_nettype none

package ubac_pkg;

  localparam int WORD_W   = 64;
  localparam int OFS_W    = 6;
  localparam int SHAMT_W  = 7;
  localparam int COUNT_W  = 12;
  localparam int INDEX_W  = 6;
  localparam int REG_IDX_W = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_SRC_OFS   = 2'd0,
    REG_DST_OFS   = 2'd1,
    REG_BIT_COUNT = 2'd2
  } reg_index_t;

  // One destination-word result
  typedef struct packed {
    logic [INDEX_W-1:0] dest_word_index;
    logic [WORD_W-1:0]  and_mask;
    logic               write_needed;
    logic               last_result;
  } result_t;

  // Mask with the low k bits set; k of 64 or more gives all ones
  function automatic logic [WORD_W-1:0] low_ones(input logic [SHAMT_W-1:0] k);
    logic [WORD_W-1:0] m;
    if (k >= SHAMT_W'(WORD_W)) begin
      m = ALL_ONES;
    end else begin
      m = (WORD_W'(1) << k) - WORD_W'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/ubac_in_if.sv */
// Source-word input channel: valid/ready plus one 64-bit source word.
// Depends on ubac_pkg for widths.
`default_nettype none

interface ubac_in_if;
  logic                          valid;
  logic                          ready;
  logic [ubac_pkg::WORD_W-1:0]   source_word;

  modport source (output valid, output source_word, input ready);
  modport sink   (input valid, input source_word, output ready);
endinterface

`default_nettype wire

/* rtl/ubac_out_if.sv */
// Result channel: valid/ready plus destination index, AND mask and flags.
// Depends on ubac_pkg for widths.
`default_nettype none

interface ubac_out_if;
  logic                           valid;
  logic                           ready;
  logic [ubac_pkg::INDEX_W-1:0]   dest_word_index;
  logic [ubac_pkg::WORD_W-1:0]    and_mask;
  logic                           write_needed;
  logic                           last_result;

  modport source (output valid, output dest_word_index, output and_mask,
                  output write_needed, output last_result, input ready);
  modport sink   (input valid, input dest_word_index, input and_mask,
                  input write_needed, input last_result, output ready);
endinterface

`default_nettype wire

/* rtl/ubac_cfg_if.sv */
// Configuration write channel: valid/ready, register index and write data.
// Depends on ubac_pkg for widths.
`default_nettype none

interface ubac_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ubac_pkg::REG_IDX_W-1:0]  reg_index;
  logic [ubac_pkg::COUNT_W-1:0]    write_data;

  modport source (output valid, output reg_index, output write_data, input ready);
  modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

`default_nettype wire

/* rtl/unaligned_bitmap_and_copy.sv */
// Top level of the unaligned bitmap AND-copy block: funnel alignment of source
// words into per-destination-word AND masks. Depends on ubac_pkg and the
// ubac_in_if, ubac_out_if and ubac_cfg_if interfaces.
//
// Usage:
//   in_ch  carries one 64-bit source word per transfer. Each word is aligned
//          and merged into the mask of the current destination word in the
//          cycle it is taken; run state lives in registers.
//   out_ch carries one destination word per transfer: index (mod 64), AND
//          mask (ones outside the window), write_needed and last_result.
//          A source word yields zero, one or two results.
//   cfg    writes source offset (0), destination offset (1), bit count (2).
//          Always ready; a write to a known register restarts the run.
// Results are written into the result queue on the source word transfer and
// read from its head. Throughput: one source word per cycle, limited by the
// 4-entry result queue, which takes a word only while it has two free slots;
// the output side drains one result per cycle while out_ch.ready is high.
// Reset (rst, synchronous) restores offsets 0/0, bit count 64, and empties
// the queue. When the receiver stalls, the queue fills and in_ch.ready drops.
`default_nettype none

module unaligned_bitmap_and_copy #(
  parameter int MAX_BITS = 2048
) (
  input  wire logic clk,
  input  wire logic rst,
  ubac_in_if.sink   in_ch,
  ubac_out_if.source out_ch,
  ubac_cfg_if.sink  cfg
);

  localparam int CNT_W = $clog2(MAX_BITS + 1);
  localparam int W  = ubac_pkg::WORD_W;
  localparam int SW = ubac_pkg::SHAMT_W;
  localparam int OW = ubac_pkg::OFS_W;

  // Configuration registers
  logic [OW-1:0]                  src_ofs;
  logic [OW-1:0]                  dst_ofs;
  logic [ubac_pkg::COUNT_W-1:0]   bit_count;

  // Run state
  logic [W-1:0]                   pend_mask;
  logic [CNT_W-1:0]               bits_done;
  logic [ubac_pkg::INDEX_W-1:0]   dest_count;
  logic                           run_active;

  // Result queue
  ubac_pkg::result_t              fifo [ubac_pkg::FIFO_DEPTH];
  logic [ubac_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [ubac_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [ubac_pkg::FIFO_CNT_W-1:0] fifo_cnt;

  // Datapath signals
  logic [CNT_W-1:0]               n_eff;
  logic                           run_clr;
  logic [W-1:0]                   pm_eff;
  logic [CNT_W-1:0]               bd_eff;
  logic [ubac_pkg::INDEX_W-1:0]   dc_eff;
  logic                           act_eff;
  logic [OW-1:0]                  lo;
  logic [CNT_W-1:0]               rem;
  logic [SW-1:0]                  w_max;
  logic [SW-1:0]                  w;
  logic [OW-1:0]                  r;
  logic [SW-1:0]                  a_max;
  logic [SW-1:0]                  a;
  logic [SW-1:0]                  b;
  logic [W-1:0]                   zeros;
  logic [W-1:0]                   pm1;
  logic [W-1:0]                   pm_base;
  logic [W-1:0]                   pm2;
  logic                           word_full;
  logic [ubac_pkg::INDEX_W-1:0]   dc2;
  logic [CNT_W-1:0]               bd2;
  logic                           run_done;
  logic                           tail;
  ubac_pkg::result_t              res0;
  ubac_pkg::result_t              res1;
  ubac_pkg::result_t              first_res;
  logic [1:0]                     push_n;
  logic                           in_xfer;
  logic                           out_xfer;
  logic                           cfg_hit;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign cfg_hit  = cfg.valid && cfg.ready &&
                    (cfg.reg_index == ubac_pkg::REG_SRC_OFS ||
                     cfg.reg_index == ubac_pkg::REG_DST_OFS ||
                     cfg.reg_index == ubac_pkg::REG_BIT_COUNT);

  // Effective bit count: zero reads as one, saturate at MAX_BITS
  always_comb begin
    if (bit_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(bit_count) > 32'(MAX_BITS)) begin
      n_eff = CNT_W'(MAX_BITS);
    end else begin
      n_eff = CNT_W'(bit_count);
    end
  end

  // Funnel alignment and mask merge for one source word
  always_comb begin
    run_clr = (bits_done >= n_eff);
    pm_eff  = run_clr ? ubac_pkg::ALL_ONES : pend_mask;
    bd_eff  = run_clr ? '0 : bits_done;
    dc_eff  = run_clr ? '0 : dest_count;
    act_eff = run_clr ? 1'b0 : run_active;

    lo    = act_eff ? '0 : src_ofs;
    rem   = n_eff - bd_eff;
    w_max = SW'(W) - {1'b0, lo};
    w     = (CNT_W'(w_max) > rem) ? SW'(rem) : w_max;

    r     = dst_ofs + bd_eff[OW-1:0];
    a_max = SW'(W) - {1'b0, r};
    a     = (a_max > w) ? w : a_max;
    b     = w - a;

    zeros = (~in_ch.source_word) >> lo;
    pm1   = pm_eff & ~((zeros & ubac_pkg::low_ones(a)) << r);
    word_full = (({1'b0, r} + a) == SW'(W));

    pm_base = word_full ? ubac_pkg::ALL_ONES : pm1;
    pm2     = (b != '0) ? (pm_base & ~((zeros >> a) & ubac_pkg::low_ones(b))) : pm_base;
    dc2     = dc_eff + ubac_pkg::INDEX_W'(word_full);

    bd2      = bd_eff + CNT_W'(w);
    run_done = (bd2 >= n_eff);
    tail     = run_done && ((dst_ofs + bd2[OW-1:0]) != '0);

    res0.dest_word_index = dc_eff;
    res0.and_mask        = pm1;
    res0.write_needed    = (pm1 != ubac_pkg::ALL_ONES);
    res0.last_result     = run_done && !tail;

    res1.dest_word_index = dc2;
    res1.and_mask        = pm2;
    res1.write_needed    = (pm2 != ubac_pkg::ALL_ONES);
    res1.last_result     = 1'b1;

    first_res = word_full ? res0 : res1;
    push_n    = 2'(word_full) + 2'(tail);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_ofs   <= '0;
      dst_ofs   <= '0;
      bit_count <= ubac_pkg::COUNT_W'(64);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.reg_index)
        ubac_pkg::REG_SRC_OFS:   src_ofs   <= cfg.write_data[OW-1:0];
        ubac_pkg::REG_DST_OFS:   dst_ofs   <= cfg.write_data[OW-1:0];
        ubac_pkg::REG_BIT_COUNT: bit_count <= cfg.write_data;
        default: ;
      endcase
    end
  end

  // Run state update
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      pend_mask  <= ubac_pkg::ALL_ONES;
      bits_done  <= '0;
      dest_count <= '0;
      run_active <= 1'b0;
    end else if (in_xfer) begin
      if (run_done) begin
        pend_mask  <= ubac_pkg::ALL_ONES;
        bits_done  <= '0;
        dest_count <= '0;
        run_active <= 1'b0;
      end else begin
        pend_mask  <= pm2;
        bits_done  <= bd2;
        dest_count <= dc2;
        run_active <= 1'b1;
      end
    end
  end

  // Result queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (in_xfer) begin
        wr_ptr <= wr_ptr + ubac_pkg::FIFO_PTR_W'(push_n);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fifo_cnt <= fifo_cnt + (in_xfer ? ubac_pkg::FIFO_CNT_W'(push_n) : '0)
                  - ubac_pkg::FIFO_CNT_W'(out_xfer);
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (in_xfer && push_n != 2'd0) begin
      fifo[wr_ptr] <= first_res;
    end
    if (in_xfer && push_n == 2'd2) begin
      fifo[wr_ptr + 1'b1] <= res1;
    end
  end

  // Channel outputs
  assign in_ch.ready = (fifo_cnt <= ubac_pkg::FIFO_CNT_W'(ubac_pkg::FIFO_DEPTH - 2));
  assign cfg.ready   = 1'b1;

  assign out_ch.valid           = (fifo_cnt != '0);
  assign out_ch.dest_word_index = fifo[rd_ptr].dest_word_index;
  assign out_ch.and_mask        = fifo[rd_ptr].and_mask;
  assign out_ch.write_needed    = fifo[rd_ptr].write_needed;
  assign out_ch.last_result     = fifo[rd_ptr].last_result;

endmodule

`default_nettype wire

/* rtl/ubac_checker.sv */
// Port-level checks for unaligned_bitmap_and_copy, bound to the top level.
// Depends on ubac_pkg for widths and the all-ones constant.
`default_nettype none

module ubac_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [ubac_pkg::INDEX_W-1:0]  out_index,
  input wire logic [ubac_pkg::WORD_W-1:0]   out_mask,
  input wire logic                          out_write_needed,
  input wire logic                          out_last,
  input wire logic                          cfg_valid,
  input wire logic                          cfg_ready
);

  // write_needed flags exactly the masks that change the destination
  a_write_needed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_write_needed == (out_mask != ubac_pkg::ALL_ONES)))
    else $error("write_needed does not match and_mask");

  // A stalled result holds its index, mask and last flag
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_mask) &&
      $stable(out_index) && $stable(out_last))
    else $error("stalled result changed");

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending right after reset");

  // Configuration writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind unaligned_bitmap_and_copy ubac_checker u_ubac_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_index        (out_ch.dest_word_index),
  .out_mask         (out_ch.and_mask),
  .out_write_needed (out_ch.write_needed),
  .out_last         (out_ch.last_result),
  .cfg_valid        (cfg.valid),
  .cfg_ready        (cfg.ready)
);

`default_nettype wire
